### hdl/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared types and constants of the latest-frame slot manager: slot count,
// operation codes, slot states, register indexes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  // Number of frame slots (2 to 8) and the width of a slot index
  localparam int SLOTS  = 2;
  localparam int SLOT_W = $clog2(SLOTS);

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_CLAIM   = 3'd0;
  localparam logic [2:0] MODE_PUBLISH = 3'd1;
  localparam logic [2:0] MODE_ABANDON = 3'd2;
  localparam logic [2:0] MODE_TAKE    = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CANVAS  = 2'd0;
  localparam logic [1:0] REG_PLACE_X = 2'd1;
  localparam logic [1:0] REG_PLACE_Y = 2'd2;

  // Address width of the configuration port
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_FILLING = 2'd1,
    ST_READY   = 2'd2,
    ST_IN_USE  = 2'd3
  } slot_status_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;    // capture the incoming word
    logic              step;    // examine one slot of the newest-frame scan
    logic [SLOT_W-1:0] idx;     // slot under examination
    logic              commit;  // apply the operation and load the result
  } lfsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_take;  // incoming word asks for the newest frame
  } lfsm_sts_t;

endpackage

### hdl/latest_frame_slot_manager.sv
// ----------------------------------------------------------------------------
// latest_frame_slot_manager
// Frame slot manager between a picture producer and a display consumer.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one operation word: claim,
// publish, abandon, take newest or release. Every word yields exactly one
// result word on the output channel (out_valid/out_ready) with the grant,
// the taken frame's dimensions and placement, and the running shown and
// dropped frame counts.
// A word is accepted only while the sequencer is idle. Claim, publish,
// abandon and release go from the accepting edge to the done state and
// commit their result into the output register from there; take newest
// first walks the slot table one slot per cycle to find the newest ready
// frame, then commits. The next word can be accepted as the result appears.
// The result sits in an output register; if the receiver stalls, the next
// word is still accepted and worked on, and its commit waits until the
// held result is taken.
// Reset frees all slots, clears all counters and the placement registers.
// The APB port writes canvas_number, place_x and place_y at byte addresses
// 0, 4 and 8; write them only while no word is in flight.
// ----------------------------------------------------------------------------
module latest_frame_slot_manager (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Operation channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 mode,
  input  logic [2:0]                 target_slot,
  input  logic [8:0]                 pic_width,
  input  logic [8:0]                 pic_height,
  input  logic [8:0]                 pic_stride,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       granted,
  output logic [2:0]                 granted_slot,
  output logic [8:0]                 frame_width,
  output logic [8:0]                 frame_height,
  output logic [8:0]                 frame_stride,
  output logic [15:0]                out_canvas,
  output logic signed [15:0]         out_x,
  output logic signed [15:0]         out_y,
  output logic [31:0]                shown_total,
  output logic [31:0]                dropped_total
);

  logic [15:0]         canvas_number;
  logic signed [15:0]  place_x;
  logic signed [15:0]  place_y;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  lfsm_pkg::lfsm_cmd_t cmd;
  lfsm_pkg::lfsm_sts_t sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_number <= '0;
      place_x       <= '0;
      place_y       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lfsm_pkg::REG_CANVAS:  canvas_number <= pwdata[15:0];
        lfsm_pkg::REG_PLACE_X: place_x       <= pwdata[15:0];
        lfsm_pkg::REG_PLACE_Y: place_y       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      lfsm_pkg::REG_CANVAS:  prdata = {16'd0, canvas_number};
      lfsm_pkg::REG_PLACE_X: prdata = 32'(place_x);
      lfsm_pkg::REG_PLACE_Y: prdata = 32'(place_y);
      default:               prdata = '0;
    endcase
  end

  lfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfsm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .target_slot   (target_slot),
    .pic_width     (pic_width),
    .pic_height    (pic_height),
    .pic_stride    (pic_stride),
    .cfg_canvas    (canvas_number),
    .cfg_x         (place_x),
    .cfg_y         (place_y),
    .granted       (granted),
    .granted_slot  (granted_slot),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .frame_stride  (frame_stride),
    .out_canvas    (out_canvas),
    .out_x         (out_x),
    .out_y         (out_y),
    .shown_total   (shown_total),
    .dropped_total (dropped_total)
  );

endmodule

### hdl/lfsm_ctrl.sv
// ----------------------------------------------------------------------------
// lfsm_ctrl
// Sequencer of the slot manager: accepts a word, walks the slots for a take,
// then commits once the result register is free.
// ----------------------------------------------------------------------------
module lfsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lfsm_pkg::lfsm_sts_t sts,
  output lfsm_pkg::lfsm_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [lfsm_pkg::SLOT_W-1:0] LAST_IDX = lfsm_pkg::SLOT_W'(lfsm_pkg::SLOTS - 1);

  state_t                      state;
  logic [lfsm_pkg::SLOT_W-1:0] scan_idx;
  logic                        accept;
  logic                        commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  // Drive the datapath
  always_comb begin
    cmd.load   = accept;
    cmd.step   = (state == S_SCAN);
    cmd.idx    = scan_idx;
    cmd.commit = commit;
  end

  // Hold state, scan index and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            state <= sts.in_take ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/lfsm_dp.sv
// ----------------------------------------------------------------------------
// lfsm_dp
// Datapath of the slot manager: slot table, sequence and frame counters,
// newest-frame scan registers and the result register.
// ----------------------------------------------------------------------------
module lfsm_dp (
  input  logic                clk,
  input  logic                rst,
  input  lfsm_pkg::lfsm_cmd_t cmd,
  output lfsm_pkg::lfsm_sts_t sts,
  input  logic [2:0]          mode,
  input  logic [2:0]          target_slot,
  input  logic [8:0]          pic_width,
  input  logic [8:0]          pic_height,
  input  logic [8:0]          pic_stride,
  input  logic [15:0]         cfg_canvas,
  input  logic [15:0]         cfg_x,
  input  logic [15:0]         cfg_y,
  output logic                granted,
  output logic [2:0]          granted_slot,
  output logic [8:0]          frame_width,
  output logic [8:0]          frame_height,
  output logic [8:0]          frame_stride,
  output logic [15:0]         out_canvas,
  output logic signed [15:0]  out_x,
  output logic signed [15:0]  out_y,
  output logic [31:0]         shown_total,
  output logic [31:0]         dropped_total
);

  localparam int SW = lfsm_pkg::SLOT_W;

  // Captured word
  logic [2:0]  mode_q;
  logic [2:0]  tgt_q;
  logic [8:0]  pw_q;
  logic [8:0]  ph_q;
  logic [8:0]  ps_q;

  // Slot table
  lfsm_pkg::slot_status_t slot_status [lfsm_pkg::SLOTS];
  logic [31:0]            slot_seq    [lfsm_pkg::SLOTS];
  logic [8:0]             slot_width  [lfsm_pkg::SLOTS];
  logic [8:0]             slot_height [lfsm_pkg::SLOTS];
  logic [8:0]             slot_stride [lfsm_pkg::SLOTS];

  logic [31:0] seq_count;
  logic [31:0] shown_count;
  logic [31:0] dropped_count;

  // Newest-frame scan
  logic          best_valid;
  logic [SW-1:0] best_idx;
  logic [31:0]   best_seq;
  logic [31:0]   scan_seq;

  // Commit logic
  lfsm_pkg::slot_status_t status_next [lfsm_pkg::SLOTS];
  logic          free_hit;
  logic [SW-1:0] free_idx;
  logic          ready_hit;
  logic [SW-1:0] ready_idx;
  logic          tgt_ok;
  logic [SW-1:0] tgt_idx;
  logic [3:0]    drop_inc;
  logic          res_granted;
  logic [SW-1:0] res_slot;
  logic          res_take;
  logic          do_publish;
  logic [31:0]   seq_next;
  logic [31:0]   shown_next;
  logic [31:0]   dropped_next;

  assign sts.in_take = (mode == lfsm_pkg::MODE_TAKE);

  assign tgt_ok   = ({1'b0, tgt_q} < 4'(lfsm_pkg::SLOTS));
  assign tgt_idx  = tgt_q[SW-1:0];
  assign scan_seq = slot_seq[cmd.idx];

  // Find the lowest free and the lowest ready slot
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    ready_hit = 1'b0;
    ready_idx = '0;
    for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
      if (!free_hit && slot_status[i] == lfsm_pkg::ST_FREE) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
      if (!ready_hit && slot_status[i] == lfsm_pkg::ST_READY) begin
        ready_hit = 1'b1;
        ready_idx = SW'(i);
      end
    end
  end

  // Work out the slot table and counters after the operation
  always_comb begin
    for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
      status_next[i] = slot_status[i];
    end
    res_granted = 1'b0;
    res_slot    = '0;
    res_take    = 1'b0;
    do_publish  = 1'b0;
    drop_inc    = '0;
    unique case (mode_q)
      lfsm_pkg::MODE_CLAIM: begin
        if (free_hit || ready_hit) begin
          res_granted = 1'b1;
          res_slot    = free_hit ? free_idx : ready_idx;
          status_next[res_slot] = lfsm_pkg::ST_FILLING;
        end
      end
      lfsm_pkg::MODE_PUBLISH: begin
        if (tgt_ok) begin
          do_publish = 1'b1;
          status_next[tgt_idx] = lfsm_pkg::ST_READY;
        end
      end
      lfsm_pkg::MODE_ABANDON: begin
        if (tgt_ok) begin
          status_next[tgt_idx] = lfsm_pkg::ST_FREE;
        end
      end
      lfsm_pkg::MODE_TAKE: begin
        if (best_valid) begin
          res_granted = 1'b1;
          res_take    = 1'b1;
          res_slot    = best_idx;
          // Free and count every older ready frame
          for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
            if (SW'(i) != best_idx && slot_status[i] == lfsm_pkg::ST_READY) begin
              status_next[i] = lfsm_pkg::ST_FREE;
              drop_inc = drop_inc + 4'd1;
            end
          end
          status_next[best_idx] = lfsm_pkg::ST_IN_USE;
        end
      end
      lfsm_pkg::MODE_RELEASE: begin
        for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
          if (slot_status[i] == lfsm_pkg::ST_IN_USE) begin
            status_next[i] = lfsm_pkg::ST_FREE;
          end
        end
      end
      default: begin
        res_granted = 1'b0;
      end
    endcase
    seq_next     = seq_count + 32'(do_publish);
    shown_next   = shown_count + 32'(res_take);
    dropped_next = dropped_count + 32'(drop_inc);
  end

  // Capture the word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      tgt_q  <= target_slot;
      pw_q   <= pic_width;
      ph_q   <= pic_height;
      ps_q   <= pic_stride;
    end
  end

  // Track the newest ready slot; a later slot wins only on a larger sequence
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_valid <= 1'b0;
      best_idx   <= '0;
      best_seq   <= '0;
    end else if (cmd.step) begin
      if (slot_status[cmd.idx] == lfsm_pkg::ST_READY &&
          (!best_valid || scan_seq > best_seq)) begin
        best_valid <= 1'b1;
        best_idx   <= cmd.idx;
        best_seq   <= scan_seq;
      end
    end
  end

  // Update slot states and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
        slot_status[i] <= lfsm_pkg::ST_FREE;
      end
      seq_count     <= '0;
      shown_count   <= '0;
      dropped_count <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
        slot_status[i] <= status_next[i];
      end
      seq_count     <= seq_next;
      shown_count   <= shown_next;
      dropped_count <= dropped_next;
    end
  end

  // Stamp a published slot
  always_ff @(posedge clk) begin
    if (cmd.commit && do_publish) begin
      slot_seq[tgt_idx]    <= seq_next;
      slot_width[tgt_idx]  <= pw_q;
      slot_height[tgt_idx] <= ph_q;
      slot_stride[tgt_idx] <= ps_q;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted       <= res_granted;
      granted_slot  <= 3'(res_slot);
      frame_width   <= res_take ? slot_width[best_idx]  : 9'd0;
      frame_height  <= res_take ? slot_height[best_idx] : 9'd0;
      frame_stride  <= res_take ? slot_stride[best_idx] : 9'd0;
      out_canvas    <= res_take ? cfg_canvas : 16'd0;
      out_x         <= res_take ? cfg_x : 16'sd0;
      out_y         <= res_take ? cfg_y : 16'sd0;
      shown_total   <= shown_next;
      dropped_total <= dropped_next;
    end
  end

endmodule

### bench/tb_latest_frame_slot_manager.sv
// ----------------------------------------------------------------------------
// tb_latest_frame_slot_manager
// Self-checking bench for the latest-frame slot manager. A slot-table
// predictor in the scoreboard follows every accepted operation word and
// queues the result word it must produce; each result word is compared
// field by field in order. A directed opener hits claim order, publish on
// filling and in-use slots, dropped frames, out-of-range slots and unused modes.
// Random phases with varied placement registers then run with and without
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_latest_frame_slot_manager;
  import lfsm_pkg::*;

  // Modes with no operation behind them
  localparam logic [2:0] MODE_BAD_FIRST = 3'd5;
  localparam logic [2:0] MODE_BAD_LAST  = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 264;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] slot;
    logic [8:0] width;
    logic [8:0] height;
    logic [8:0] stride;
  } op_word_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  slot;
    logic [8:0]  width;
    logic [8:0]  height;
    logic [8:0]  stride;
    logic [15:0] canvas;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] shown;
    logic [31:0] dropped;
  } frame_result_t;

  // Slot table tracker and queue of result words still owed
  class frame_slot_board;
    slot_status_t    status[SLOTS];
    logic [31:0]     seq[SLOTS];
    logic [8:0]      wid[SLOTS];
    logic [8:0]      hgt[SLOTS];
    logic [8:0]      str[SLOTS];
    logic [31:0]     seq_ctr;
    logic [31:0]     shown;
    logic [31:0]     dropped;
    logic [15:0]     canvas;
    logic [15:0]     px;
    logic [15:0]     py;
    frame_result_t   owed[$];
    int              errors;
    int              last_claim;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        status[i] = ST_FREE;
        seq[i] = '0;
        wid[i] = '0;
        hgt[i] = '0;
        str[i] = '0;
      end
      seq_ctr = '0;
      shown = '0;
      dropped = '0;
      canvas = '0;
      px = '0;
      py = '0;
      errors = 0;
      last_claim = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_CANVAS:  canvas = v;
        REG_PLACE_X: px = v;
        REG_PLACE_Y: py = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted word to the slot table and queue its result
    function void note_word(op_word_t w);
      frame_result_t r;
      int pick;
      r = '0;
      pick = -1;
      case (w.op)
        MODE_CLAIM: begin
          // lowest free slot first, else overwrite the lowest ready one
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && status[i] == ST_FREE) pick = i;
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && status[i] == ST_READY) pick = i;
          if (pick >= 0) begin
            status[pick] = ST_FILLING;
            r.granted = 1'b1;
            r.slot = pick[2:0];
            last_claim = pick;
          end
        end
        MODE_PUBLISH: begin
          if (w.slot < SLOTS) begin
            seq_ctr = seq_ctr + 32'd1;
            seq[w.slot] = seq_ctr;
            wid[w.slot] = w.width;
            hgt[w.slot] = w.height;
            str[w.slot] = w.stride;
            status[w.slot] = ST_READY;
          end
        end
        MODE_ABANDON: begin
          if (w.slot < SLOTS) status[w.slot] = ST_FREE;
        end
        MODE_TAKE: begin
          for (int i = 0; i < SLOTS; i++)
            if (status[i] == ST_READY && (pick < 0 || seq[i] > seq[pick])) pick = i;
          if (pick >= 0) begin
            // drop every older ready frame
            for (int i = 0; i < SLOTS; i++)
              if (i != pick && status[i] == ST_READY) begin
                status[i] = ST_FREE;
                dropped = dropped + 32'd1;
              end
            status[pick] = ST_IN_USE;
            shown = shown + 32'd1;
            r.granted = 1'b1;
            r.slot = pick[2:0];
            r.width = wid[pick];
            r.height = hgt[pick];
            r.stride = str[pick];
            r.canvas = canvas;
            r.x = px;
            r.y = py;
          end
        end
        MODE_RELEASE: begin
          for (int i = 0; i < SLOTS; i++)
            if (status[i] == ST_IN_USE) status[i] = ST_FREE;
        end
        default: ;
      endcase
      r.shown = shown;
      r.dropped = dropped;
      owed.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result word with the oldest owed one
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      want = owed.pop_front();
      match_field("granted", 32'(want.granted), 32'(got.granted));
      match_field("granted_slot", 32'(want.slot), 32'(got.slot));
      match_field("frame_width", 32'(want.width), 32'(got.width));
      match_field("frame_height", 32'(want.height), 32'(got.height));
      match_field("frame_stride", 32'(want.stride), 32'(got.stride));
      match_field("out_canvas", 32'(want.canvas), 32'(got.canvas));
      match_field("out_x", 32'(want.x), 32'(got.x));
      match_field("out_y", 32'(want.y), 32'(got.y));
      match_field("shown_total", want.shown, got.shown);
      match_field("dropped_total", want.dropped, got.dropped);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          mode = '0;
  logic [2:0]          target_slot = '0;
  logic [8:0]          pic_width = '0;
  logic [8:0]          pic_height = '0;
  logic [8:0]          pic_stride = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                granted;
  logic [2:0]          granted_slot;
  logic [8:0]          frame_width;
  logic [8:0]          frame_height;
  logic [8:0]          frame_stride;
  logic [15:0]         out_canvas;
  logic signed [15:0]  out_x;
  logic signed [15:0]  out_y;
  logic [31:0]         shown_total;
  logic [31:0]         dropped_total;

  frame_result_t       result_bus;
  frame_slot_board     board;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  idle_cycles = 0;

  latest_frame_slot_manager u_dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .mode, .target_slot, .pic_width, .pic_height, .pic_stride,
    .out_valid, .out_ready, .granted, .granted_slot, .frame_width, .frame_height,
    .frame_stride, .out_canvas, .out_x, .out_y, .shown_total, .dropped_total
  );

  assign result_bus = {granted, granted_slot, frame_width, frame_height, frame_stride,
                       out_canvas, out_x, out_y, shown_total, dropped_total};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each result word taken and pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(result_bus);
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_latest_frame_slot_manager: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, with random gaps ahead of it, and hold it until taken
  task automatic push_word(input op_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= w.op;
    target_slot <= w.slot;
    pic_width <= w.width;
    pic_height <= w.height;
    pic_stride <= w.stride;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
  endtask

  task automatic put(input logic [2:0] op, input logic [2:0] slot,
                     input logic [8:0] w, input logic [8:0] h, input logic [8:0] s);
    push_word('{op, slot, w, h, s});
  endtask

  // Wait out every owed result plus the longest scan
  task automatic drain_results();
    do @(posedge clk); while (board.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, v);
  endtask

  task automatic set_placement(input logic [15:0] c, input logic [15:0] x,
                               input logic [15:0] y);
    write_reg(REG_CANVAS, c);
    write_reg(REG_PLACE_X, x);
    write_reg(REG_PLACE_Y, y);
  endtask

  // Mostly well-formed producer/consumer traffic, some noise
  function automatic op_word_t make_word();
    op_word_t w;
    int r;
    int t;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, 99);
    w.slot = 3'($urandom_range(0, 7));
    w.width = 9'($urandom_range(0, 448));
    w.height = 9'($urandom_range(0, 256));
    w.stride = 9'($urandom_range(0, 448));
    if (r < 24) begin
      w.op = MODE_CLAIM;
    end else if (r < 48) begin
      w.op = MODE_PUBLISH;
      if (t < 75) w.slot = 3'(board.last_claim);
      else if (t < 95) w.slot = 3'($urandom_range(0, SLOTS - 1));
    end else if (r < 56) begin
      w.op = MODE_ABANDON;
      if (t < 85) w.slot = 3'($urandom_range(0, SLOTS - 1));
    end else if (r < 78) begin
      w.op = MODE_TAKE;
    end else if (r < 95) begin
      w.op = MODE_RELEASE;
    end else begin
      w.op = 3'($urandom_range(MODE_BAD_FIRST, MODE_BAD_LAST));
    end
    return w;
  endfunction

  function automatic bit does_work(op_word_t w);
    if (w.op > MODE_RELEASE) return 1'b0;
    if ((w.op == MODE_PUBLISH || w.op == MODE_ABANDON) && w.slot >= SLOTS) return 1'b0;
    return 1'b1;
  endfunction

  task automatic run_phase(input int send_pct, input int stall, input bit with_pause);
    op_word_t w;
    int useful;
    int sent;
    useful = 0;
    sent = 0;
    send_idle_pct = send_pct;
    stall_pct = stall;
    while (useful < PHASE_ITEMS) begin
      // hold off until the block has emptied once
      if (with_pause && sent == PHASE_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      w = make_word();
      useful += int'(does_work(w));
      sent++;
      push_word(w);
    end
    in_valid <= 1'b0;
    drain_results();
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opener with placement still at its reset value
    put(MODE_TAKE, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_RELEASE, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_CLAIM, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_CLAIM, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_CLAIM, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_PUBLISH, 3'd0, 9'd448, 9'd256, 9'd448);
    put(MODE_PUBLISH, 3'd1, 9'd0, 9'd0, 9'd0);
    // no free slot: claim overwrites the lowest ready one
    put(MODE_CLAIM, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_TAKE, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_PUBLISH, 3'd0, 9'h155, 9'h0aa, 9'h1aa);
    // publish an in-use slot: it goes ready anyway
    put(MODE_PUBLISH, 3'd1, 9'h0aa, 9'h100, 9'h055);
    put(MODE_TAKE, 3'd0, 9'd0, 9'd0, 9'd0);
    // slot indexes past the table change nothing
    put(MODE_PUBLISH, 3'd2, 9'd1, 9'd1, 9'd1);
    put(MODE_PUBLISH, 3'd7, 9'd448, 9'd256, 9'd448);
    put(MODE_ABANDON, 3'd5, 9'd0, 9'd0, 9'd0);
    put(MODE_ABANDON, 3'd1, 9'd0, 9'd0, 9'd0);
    put(MODE_BAD_FIRST, 3'd7, 9'd448, 9'd256, 9'd448);
    put(3'd6, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_BAD_LAST, 3'd2, 9'h0ff, 9'h0ff, 9'h0ff);
    put(MODE_CLAIM, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_PUBLISH, 3'd0, 9'd320, 9'd240, 9'd384);
    put(MODE_TAKE, 3'd0, 9'd0, 9'd0, 9'd0);
    put(MODE_RELEASE, 3'd0, 9'd0, 9'd0, 9'd0);
    in_valid <= 1'b0;
    drain_results();

    // Random phases, each under its own placement and idling mix
    set_placement(16'hffff, 16'h8000, 16'h7fff);
    run_phase(0, 0, 1'b0);
    set_placement(16'h0000, 16'h7fff, 16'h8000);
    run_phase(48, 0, 1'b1);
    set_placement(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    run_phase(0, 48, 1'b0);
    set_placement(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    run_phase(12, 12, 1'b0);

    // Catch any stray result words
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_latest_frame_slot_manager: clean");
    end else begin
      $display("tb_latest_frame_slot_manager: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lfsm_pkg.sv
hdl/lfsm_ctrl.sv
hdl/lfsm_dp.sv
hdl/latest_frame_slot_manager.sv
bench/tb_latest_frame_slot_manager.sv
